[rtl/shssc_pkg.sv]
// Package for the half-step stepper speed controller.
// Transaction types, register indexes, reset values and the coil table.
// No dependencies.
package shssc_pkg;

  localparam int POSITION_BITS = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [9:0]  LOW_THRESHOLD_RST  = 10'd300;
  localparam logic [9:0]  HIGH_THRESHOLD_RST = 10'd700;
  localparam logic [11:0] IDLE_LIMIT_RST     = 12'd1000;
  localparam logic [2:0]  MAX_SPEED_RST      = 3'd5;
  localparam logic [2:0]  SPEED_INDEX_RST    = 3'd1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_THRESHOLD  = 8'd0,
    REG_HIGH_THRESHOLD = 8'd1,
    REG_IDLE_LIMIT     = 8'd2,
    REG_MAX_SPEED      = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [9:0] joy_sample;
    logic       faster_button;
    logic       slower_button;
    logic       alert_busy;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         coil_pattern;
    logic signed [15:0] step_position;
    logic               moving;
    logic [2:0]         speed_level;
    logic               sped_up;
    logic               slowed_down;
    logic               idle_alert;
  } out_item_t;

  // Half-step coil drive sequence.
  function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      3'd7:    pat = 4'b1001;
      default: pat = 4'b0001;
    endcase
    return pat;
  endfunction

endpackage

[rtl/stepper_half_step_speed_controller_core.sv]
// Top level of the half-step stepper speed controller.
// Input register, one pass of tick logic, result register.
// Depends on shssc_pkg.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | shssc_pkg::in_item_t
//  out_    | output    | out_valid/out_stall | shssc_pkg::out_item_t
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One tick per cycle unless stalled; input register, then result register.
// The tick is evaluated when the input register moves into the result register.
// A stalled result register holds the input register; in_stall rises only then.
// rst_n is synchronous: state, config and valid flags return to reset values.
// cfg_ready is always high.
module stepper_half_step_speed_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  shssc_pkg::in_item_t                 in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output shssc_pkg::out_item_t                out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shssc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [shssc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PB = shssc_pkg::POSITION_BITS;

  // config registers
  logic [9:0]  low_thr_r, high_thr_r;
  logic [11:0] idle_limit_r;
  logic [2:0]  max_speed_r;

  // tick state
  logic [2:0]    phase_r, phase_nxt;
  logic [3:0]    prescale_r, prescale_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [11:0]   idle_r, idle_nxt;
  logic [2:0]    speed_r, speed_nxt;
  logic [1:0]    last_btn_r;
  logic          primed_r;

  // pipeline
  logic                 s1_valid_r;
  shssc_pkg::in_item_t  s1_item_r;
  logic                 out_valid_r;
  shssc_pkg::out_item_t out_item_r, out_item_nxt;
  logic                 advance;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r    <= shssc_pkg::LOW_THRESHOLD_RST;
      high_thr_r   <= shssc_pkg::HIGH_THRESHOLD_RST;
      idle_limit_r <= shssc_pkg::IDLE_LIMIT_RST;
      max_speed_r  <= shssc_pkg::MAX_SPEED_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        shssc_pkg::REG_LOW_THRESHOLD:  low_thr_r    <= cfg_data[9:0];
        shssc_pkg::REG_HIGH_THRESHOLD: high_thr_r   <= cfg_data[9:0];
        shssc_pkg::REG_IDLE_LIMIT:     idle_limit_r <= cfg_data[11:0];
        shssc_pkg::REG_MAX_SPEED:      max_speed_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // tick logic
  logic        fwd, rev, moving;
  logic [3:0]  pre_inc;
  logic [12:0] idle_inc;
  logic        idle_pulse;
  logic        faster_edge, slower_edge;
  logic        sped, slowed;
  logic [2:0]  speed_mid;

  always_comb begin
    fwd     = s1_item_r.joy_sample < low_thr_r;
    rev     = !fwd && (s1_item_r.joy_sample > high_thr_r);
    moving  = fwd || rev;
    pre_inc = prescale_r + 4'd1;
    idle_inc = {1'b0, idle_r} + 13'd1;

    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    prescale_nxt = prescale_r;
    idle_nxt     = idle_r;
    idle_pulse   = 1'b0;

    if (moving) begin
      prescale_nxt = pre_inc;
      if ({1'b0, pre_inc} >= ({2'b00, speed_r} + 5'd1)) begin
        if (fwd) begin
          phase_nxt = phase_r + 3'd1;
          pos_nxt   = pos_r + PB'(1);
        end else begin
          phase_nxt = phase_r - 3'd1;
          pos_nxt   = pos_r - PB'(1);
        end
        prescale_nxt = 4'd0;
      end
      idle_nxt = 12'd0;
    end else begin
      prescale_nxt = 4'd0;
      if (!s1_item_r.alert_busy) begin
        if (idle_inc >= {1'b0, idle_limit_r}) begin
          idle_pulse = 1'b1;
          idle_nxt   = 12'd0;
        end else begin
          idle_nxt = idle_inc[11:0];
        end
      end
    end

    // faster edge acts first, slower edge sees its result
    faster_edge = primed_r && s1_item_r.faster_button && !last_btn_r[1];
    slower_edge = primed_r && s1_item_r.slower_button && !last_btn_r[0];
    sped      = faster_edge && (speed_r != 3'd0);
    speed_mid = sped ? speed_r - 3'd1 : speed_r;
    slowed    = slower_edge && (speed_mid < max_speed_r);
    speed_nxt = slowed ? speed_mid + 3'd1 : speed_mid;
    if (sped || slowed) begin
      idle_nxt   = 12'd0;
      idle_pulse = 1'b0;
    end

    out_item_nxt.coil_pattern  = shssc_pkg::coil_lookup(phase_nxt);
    out_item_nxt.step_position = 16'(signed'(pos_nxt));
    out_item_nxt.moving        = moving;
    out_item_nxt.speed_level   = speed_nxt;
    out_item_nxt.sped_up       = sped;
    out_item_nxt.slowed_down   = slowed;
    out_item_nxt.idle_alert    = idle_pulse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 3'd0;
      prescale_r  <= 4'd0;
      pos_r       <= '0;
      idle_r      <= 12'd0;
      speed_r     <= shssc_pkg::SPEED_INDEX_RST;
      last_btn_r  <= 2'b00;
      primed_r    <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        prescale_r  <= prescale_nxt;
        pos_r       <= pos_nxt;
        idle_r      <= idle_nxt;
        speed_r     <= speed_nxt;
        last_btn_r  <= {s1_item_r.faster_button, s1_item_r.slower_button};
        primed_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // checks
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  a_alert_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.idle_alert) |->
      (!out_item.moving && !out_item.sped_up && !out_item.slowed_down))
    else $error("idle alert with motion or speed change");

  a_moving_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && moving) |=> (idle_r == 12'd0))
    else $error("idle count not cleared while moving");

  a_prescale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> ({1'b0, prescale_r} <= {2'b00, $past(speed_r)} + 5'd1))
    else $error("prescaler beyond its period");

endmodule
